### hdl/http2_data_frame_extractor_unit_defines.svh
// Assertion macros for the HTTP/2 DATA frame extractor.
// Included by the top level; no other dependencies.
`ifndef HTTP2_DATA_FRAME_EXTRACTOR_UNIT_DEFINES_SVH
`define HTTP2_DATA_FRAME_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define H2DFX_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("h2dfx assertion failed");
// next-cycle implication
`define H2DFX_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("h2dfx assertion failed");
`else
`define H2DFX_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`define H2DFX_ASSERT_NXT(name, clk_s, rst_s, ante, cons)
`endif

`endif

### hdl/h2dfx_pkg.sv
// Shared types, constants and functions of the HTTP/2 DATA frame extractor.
// No dependencies.
`timescale 1ns / 1ps

package h2dfx_pkg;

  localparam int PREFACE_BYTES   = 24;
  localparam int HEADER_LEN      = 9;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [23:0] MAX_OUT_RESET = 24'd16384;

  // a partial preface replayed as a frame header: "PRI" is the length, ' ' the type
  localparam logic [23:0] PRI_SIZE_B1  = 24'h000050;
  localparam logic [23:0] PRI_SIZE_B2  = 24'h005052;
  localparam logic [23:0] PRI_SIZE_B3  = 24'h505249;
  localparam logic [7:0]  PREFACE_TYPE = 8'h20;
  localparam logic [7:0]  TYPE_DATA    = 8'h00;

  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload_byte;
    logic        has_final;
    logic        success;
    logic [23:0] length;
  } q_entry_t;

  typedef struct packed {
    logic in_preface;
  } fe_status_t;

  typedef struct packed {
    logic        skip;
    logic [3:0]  hdr_cnt;
    logic [23:0] frm_size;
    logic [7:0]  frame_type;
    logic [23:0] remaining;
  } replay_t;

  function automatic logic [7:0] preface_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h50;
      5'd1:    b = 8'h52;
      5'd2:    b = 8'h49;
      5'd3:    b = 8'h20;
      5'd4:    b = 8'h2A;
      5'd5:    b = 8'h20;
      5'd6:    b = 8'h48;
      5'd7:    b = 8'h54;
      5'd8:    b = 8'h54;
      5'd9:    b = 8'h50;
      5'd10:   b = 8'h2F;
      5'd11:   b = 8'h32;
      5'd12:   b = 8'h2E;
      5'd13:   b = 8'h30;
      5'd14:   b = 8'h0D;
      5'd15:   b = 8'h0A;
      5'd16:   b = 8'h0D;
      5'd17:   b = 8'h0A;
      5'd18:   b = 8'h53;
      5'd19:   b = 8'h4D;
      5'd20:   b = 8'h0D;
      5'd21:   b = 8'h0A;
      5'd22:   b = 8'h0D;
      5'd23:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Parser state after feeding the first k preface bytes as frame bytes.
  // From 9 bytes on, a non-DATA header is complete and the rest is skipped.
  function automatic replay_t replay_state(input logic [4:0] k);
    replay_t r;
    r = '0;
    if (k >= 5'(HEADER_LEN)) begin
      r.skip       = 1'b1;
      r.frame_type = PREFACE_TYPE;
      r.remaining  = PRI_SIZE_B3 - 24'(k - 5'(HEADER_LEN));
    end else begin
      r.hdr_cnt = k[3:0];
      case (k)
        5'd0:    r.frm_size = '0;
        5'd1:    r.frm_size = PRI_SIZE_B1;
        5'd2:    r.frm_size = PRI_SIZE_B2;
        default: r.frm_size = PRI_SIZE_B3;
      endcase
      r.frame_type = (k >= 5'd4) ? PREFACE_TYPE : TYPE_DATA;
    end
    return r;
  endfunction

endpackage

### hdl/h2dfx_front.sv
// Front end: preface match, frame header parse, classification of each byte.
// Depends on h2dfx_pkg.
`timescale 1ns / 1ps

module h2dfx_front
  import h2dfx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        push,
  input  logic        q_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  output logic        wr_en,
  output q_entry_t    wr_data,
  output fe_status_t  status
);

  typedef enum logic [2:0] {
    PH_PREFACE,
    PH_HEADER,
    PH_SKIP,
    PH_PAYLOAD,
    PH_DONE,
    PH_FAIL
  } phase_t;

  phase_t      phase, phase_next, eff_phase;
  logic [4:0]  pm, pm_next;
  logic [3:0]  hdr_cnt, hdr_next, eff_hdr;
  logic [23:0] frm_size, len_next, eff_len;
  logic [7:0]  frame_type, type_next, eff_type;
  logic [23:0] remaining, rem_next, eff_rem;
  logic [23:0] data_size, data_size_next;
  logic [23:0] max_output_bytes;

  replay_t rp;
  logic    fire, in_pre, match, run_frame, has_payload, ok;

  assign fire      = push && !q_full;
  assign cfg_ready = 1'b1;
  assign in_pre    = (phase == PH_PREFACE);
  assign match     = (data_byte == preface_byte(pm));
  assign run_frame = !in_pre || !match;
  assign rp        = replay_state(pm);

  always_comb begin
    // state seen by the byte: current, or the replayed partial preface on a mismatch
    eff_phase = phase;
    eff_hdr   = hdr_cnt;
    eff_len   = frm_size;
    eff_type  = frame_type;
    eff_rem   = remaining;
    if (in_pre && !match) begin
      eff_phase = rp.skip ? PH_SKIP : PH_HEADER;
      eff_hdr   = rp.hdr_cnt;
      eff_len   = rp.frm_size;
      eff_type  = rp.frame_type;
      eff_rem   = rp.skip ? rp.remaining : remaining;
    end

    phase_next     = eff_phase;
    pm_next        = pm;
    hdr_next       = eff_hdr;
    len_next       = eff_len;
    type_next      = eff_type;
    rem_next       = eff_rem;
    data_size_next = data_size;
    has_payload    = 1'b0;

    if (in_pre) begin
      if (match) begin
        if (pm == 5'(PREFACE_BYTES - 1)) begin
          phase_next = PH_HEADER;
          hdr_next   = '0;
          len_next   = '0;
          pm_next    = '0;
        end else begin
          pm_next = pm + 5'd1;
        end
      end else begin
        pm_next = '0;
      end
    end

    if (run_frame) begin
      case (eff_phase)
        PH_HEADER: begin
          if (eff_hdr < 4'd3) begin
            len_next = {eff_len[15:0], data_byte};
          end else if (eff_hdr == 4'd3) begin
            type_next = data_byte;
          end
          if (eff_hdr >= 4'(HEADER_LEN - 1)) begin
            hdr_next = '0;
            len_next = '0;
            if (eff_type == TYPE_DATA) begin
              if (eff_len > max_output_bytes) begin
                phase_next = PH_FAIL;
              end else begin
                data_size_next = eff_len;
                rem_next       = eff_len;
                phase_next     = (eff_len == '0) ? PH_DONE : PH_PAYLOAD;
              end
            end else if (eff_len != '0) begin
              rem_next   = eff_len;
              phase_next = PH_SKIP;
            end
          end else begin
            hdr_next = eff_hdr + 4'd1;
          end
        end
        PH_SKIP: begin
          rem_next = eff_rem - 24'd1;
          if (eff_rem == 24'd1) begin
            phase_next = PH_HEADER;
          end
        end
        PH_PAYLOAD: begin
          has_payload = 1'b1;
          rem_next    = eff_rem - 24'd1;
          if (eff_rem == 24'd1) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    ok = (phase_next == PH_DONE);
  end

  assign wr_en                = fire && (has_payload || last_byte);
  assign wr_data.has_payload  = has_payload;
  assign wr_data.payload_byte = has_payload ? data_byte : 8'h00;
  assign wr_data.has_final    = last_byte;
  assign wr_data.success      = ok;
  assign wr_data.length       = ok ? data_size_next : 24'd0;
  assign status.in_preface    = in_pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_PREFACE;
      pm               <= '0;
      hdr_cnt          <= '0;
      frm_size         <= '0;
      frame_type       <= '0;
      remaining        <= '0;
      data_size        <= '0;
      max_output_bytes <= MAX_OUT_RESET;
    end else begin
      if (cfg_valid) begin
        max_output_bytes <= cfg_data;
      end
      if (fire) begin
        if (last_byte) begin
          // end of buffer: back to the start of a new run
          phase      <= PH_PREFACE;
          pm         <= '0;
          hdr_cnt    <= '0;
          frm_size   <= '0;
          frame_type <= '0;
          remaining  <= '0;
          data_size  <= '0;
        end else begin
          phase      <= phase_next;
          pm         <= pm_next;
          hdr_cnt    <= hdr_next;
          frm_size   <= len_next;
          frame_type <= type_next;
          remaining  <= rem_next;
          data_size  <= data_size_next;
        end
      end
    end
  end

endmodule

### hdl/h2dfx_queue.sv
// Small register FIFO between the front end and the result sequencer.
// Depends on h2dfx_pkg.
`timescale 1ns / 1ps

module h2dfx_queue
  import h2dfx_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  q_entry_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output q_entry_t rd_data,
  output logic     empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/h2dfx_back.sv
// Result sequencer: expands a queue entry into a payload result and/or a final result.
// Depends on h2dfx_pkg.
`timescale 1ns / 1ps

module h2dfx_back
  import h2dfx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_entry_t    head,
  input  logic        q_empty,
  output logic        q_rd,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  payload_byte,
  output logic        is_final,
  output logic        success,
  output logic [23:0] payload_length
);

  logic payload_done;
  logic show_payload, take;

  assign empty        = q_empty;
  assign take         = pop && !q_empty;
  assign show_payload = head.has_payload && !payload_done;

  // an entry holding both results stays at the head until the final one is taken
  assign q_rd = take && !(show_payload && head.has_final);

  assign payload_byte   = show_payload ? head.payload_byte : 8'h00;
  assign is_final       = !show_payload;
  assign success        = !show_payload && head.success;
  assign payload_length = show_payload ? 24'd0 : head.length;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_done <= 1'b0;
    end else if (take) begin
      payload_done <= show_payload && head.has_final;
    end
  end

endmodule

### hdl/http2_data_frame_extractor_unit.sv
// Top level of the HTTP/2 DATA frame extractor: front end, queue, result sequencer.
// Depends on h2dfx_pkg, h2dfx_front, h2dfx_queue, h2dfx_back and the defines header.
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------------------
//   input     | push / full            | data_byte, last_byte
//   result    | pop / empty            | payload_byte, is_final, success, payload_length
//   config    | cfg_valid / cfg_ready  | cfg_data (max_output_bytes)
//
// One byte is taken per cycle while full is low; it is classified in the cycle it is accepted.
// A DATA payload byte gives one result, the marked last byte a final result;
// a last byte that is also payload gives two, delivered on consecutive pops.
// Results wait in a QUEUE_DEPTH entry queue; full rises only when it is full.
// Synchronous reset; cfg_ready is always high.
`timescale 1ns / 1ps
`include "http2_data_frame_extractor_unit_defines.svh"

module http2_data_frame_extractor_unit
  import h2dfx_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        push,
  output logic        full,
  output logic [7:0]  payload_byte,
  output logic        is_final,
  output logic        success,
  output logic [23:0] payload_length,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  q_entry_t   q_wr_data, q_head;
  logic       q_wr_en, q_full, q_rd, q_empty;
  fe_status_t status;

  assign full = q_full;

  h2dfx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .q_full    (q_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .wr_en     (q_wr_en),
    .wr_data   (q_wr_data),
    .status    (status)
  );

  h2dfx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  h2dfx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .payload_byte   (payload_byte),
    .is_final       (is_final),
    .success        (success),
    .payload_length (payload_length)
  );

  `H2DFX_ASSERT_IMP(a_no_write_when_full, clk, rst, q_wr_en, !q_full)
  `H2DFX_ASSERT_NXT(a_last_restarts_run, clk, rst, push && !full && last_byte, status.in_preface)
  `H2DFX_ASSERT_IMP(a_success_only_final, clk, rst, !empty && success, is_final)

endmodule
